FILE: sv/point_bearing_degrees_macros.svh
// ---------------------------------------------------------------------------
// Point bearing assertion macros
// Shared property wrappers for the bearing block's checker.
// ---------------------------------------------------------------------------
`ifndef POINT_BEARING_DEGREES_MACROS_SVH
`define POINT_BEARING_DEGREES_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pbd_pkg.sv
// ---------------------------------------------------------------------------
// Point bearing package
// Accumulator format, arctangent table and the tag that travels with an item.
// ---------------------------------------------------------------------------
`default_nettype none

package pbd_pkg;

    localparam int ACC_FRAC     = 20;
    localparam int CORDIC_GUARD = 16;
    localparam int ZW           = 32;
    localparam int TABLE_LEN    = 24;

    typedef logic signed [ZW-1:0] acc_t;

    // Arctangent of 2^-i in units of 2^-20 degree.
    localparam acc_t ATAN_TAB [0:TABLE_LEN-1] = '{
        32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
        32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
        32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
        32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
        32'sd917,      32'sd458,      32'sd229,      32'sd115,
        32'sd57,       32'sd29,       32'sd14,       32'sd7
    };

    typedef enum logic [1:0] {
        CARD_UP,
        CARD_RIGHT,
        CARD_DOWN,
        CARD_LEFT
    } card_t;

    typedef struct packed {
        logic  special;
        card_t card;
    } tag_t;

endpackage

`default_nettype wire

FILE: sv/pbd_cell.sv
// ---------------------------------------------------------------------------
// Point bearing CORDIC cell
// One registered vectoring micro-rotation with its own valid and ready.
// ---------------------------------------------------------------------------
`default_nettype none

module pbd_cell #(
    parameter int DW    = 35,
    parameter int STAGE = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [DW-1:0] in_x,
    input  logic signed [DW-1:0] in_y,
    input  pbd_pkg::acc_t        in_z,
    input  pbd_pkg::tag_t        in_tag,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [DW-1:0] out_x,
    output logic signed [DW-1:0] out_y,
    output pbd_pkg::acc_t        out_z,
    output pbd_pkg::tag_t        out_tag
);
    import pbd_pkg::*;

    logic                 valid_reg;
    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] y_reg, y_next;
    acc_t                 z_reg, z_next;
    tag_t                 tag_reg;
    logic signed [DW-1:0] xs, ys;
    logic                 y_pos;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        xs    = in_x >>> STAGE;
        ys    = in_y >>> STAGE;
        y_pos = !in_y[DW-1] && (in_y != '0);
        if (y_pos) begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ATAN_TAB[STAGE];
        end else begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - ATAN_TAB[STAGE];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_tag   = tag_reg;

endmodule

`default_nettype wire

FILE: sv/point_bearing_degrees.sv
// ---------------------------------------------------------------------------
// Point bearing in degrees
// Each input transaction carries two points with y growing downward; the
// result transaction carries the clockwise bearing from the first point to
// the second, 0 meaning up, in units of 2^-ANGLE_FRAC_BITS degree.
// Both channels use valid and ready. One transaction is accepted per cycle
// while the receiver keeps up, so the throughput is one pair per clock.
// The differences are registered first, each CORDIC cell then registers
// one micro-rotation, and the wrap and rounding feed the output register.
// Every stage holds its own valid bit, so empty stages close up when the
// receiver stalls; the input side keeps accepting until every stage is full.
// Reset clears all valid bits; data in flight is discarded.
// ---------------------------------------------------------------------------
`default_nettype none

module point_bearing_degrees #(
    parameter int COORD_WIDTH     = 16,
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_from_x,
    input  logic signed [COORD_WIDTH-1:0] s_from_y,
    input  logic signed [COORD_WIDTH-1:0] s_to_x,
    input  logic signed [COORD_WIDTH-1:0] s_to_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [8+ANGLE_FRAC_BITS:0]    m_bearing
);
    import pbd_pkg::*;

    localparam int DW     = COORD_WIDTH + CORDIC_GUARD + 3;
    localparam int BW     = 9 + ANGLE_FRAC_BITS;
    localparam int RSHIFT = ACC_FRAC - ANGLE_FRAC_BITS;

    localparam acc_t FULL    = acc_t'(360 * (2 ** ACC_FRAC));
    localparam acc_t BIAS    = acc_t'(2 ** (RSHIFT - 1));
    localparam acc_t Z_RIGHT = acc_t'(90 * (2 ** ACC_FRAC)) + BIAS;
    localparam acc_t Z_LEFT  = acc_t'(270 * (2 ** ACC_FRAC)) + BIAS;
    localparam acc_t WRAP_HI = FULL + BIAS;

    localparam logic [BW-1:0] B_90  = BW'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [BW-1:0] B_180 = BW'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [BW-1:0] B_270 = BW'(270 * (2 ** ANGLE_FRAC_BITS));

    logic signed [COORD_WIDTH:0] dx, dy;
    logic signed [DW-1:0]        x_pre, y_pre;
    logic                        neg;
    logic signed [DW-1:0]        x0_next, y0_next;
    acc_t                        z0_next;
    tag_t                        tag0_next;

    logic                 v0_reg;
    logic signed [DW-1:0] x0_reg, y0_reg;
    acc_t                 z0_reg;
    tag_t                 tag0_reg;

    logic                 valid_chain [0:CORDIC_STAGES];
    logic                 ready_chain [0:CORDIC_STAGES];
    logic signed [DW-1:0] x_chain     [0:CORDIC_STAGES];
    logic signed [DW-1:0] y_chain     [0:CORDIC_STAGES];
    acc_t                 z_chain     [0:CORDIC_STAGES];
    tag_t                 tag_chain   [0:CORDIC_STAGES];

    acc_t            z_end, z_wrap;
    tag_t            tag_end;
    logic [BW-1:0]   angle;
    logic [BW-1:0]   card_val;
    logic            m_valid_reg;
    logic [BW-1:0]   m_bearing_reg, m_bearing_next;

    // Differences, cardinal cases and half-plane fold.
    always_comb begin
        dx    = $signed({s_to_x[COORD_WIDTH-1], s_to_x})
              - $signed({s_from_x[COORD_WIDTH-1], s_from_x});
        dy    = $signed({s_to_y[COORD_WIDTH-1], s_to_y})
              - $signed({s_from_y[COORD_WIDTH-1], s_from_y});
        x_pre = DW'(dx) <<< CORDIC_GUARD;
        y_pre = DW'(dy) <<< CORDIC_GUARD;
        neg   = dx[COORD_WIDTH];
        if (neg) begin
            x0_next = -x_pre;
            y0_next = -y_pre;
            z0_next = Z_LEFT;
        end else begin
            x0_next = x_pre;
            y0_next = y_pre;
            z0_next = Z_RIGHT;
        end
        tag0_next.special = (dx == '0) || (dy == '0);
        if (dx == '0) begin
            tag0_next.card = dy[COORD_WIDTH] ? CARD_UP : CARD_DOWN;
        end else begin
            tag0_next.card = neg ? CARD_LEFT : CARD_RIGHT;
        end
    end

    assign s_ready = !v0_reg || ready_chain[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (s_ready) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            x0_reg   <= x0_next;
            y0_reg   <= y0_next;
            z0_reg   <= z0_next;
            tag0_reg <= tag0_next;
        end
    end

    assign valid_chain[0] = v0_reg;
    assign x_chain[0]     = x0_reg;
    assign y_chain[0]     = y0_reg;
    assign z_chain[0]     = z0_reg;
    assign tag_chain[0]   = tag0_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        pbd_cell #(
            .DW    (DW),
            .STAGE (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_chain[i]),
            .in_ready  (ready_chain[i]),
            .in_x      (x_chain[i]),
            .in_y      (y_chain[i]),
            .in_z      (z_chain[i]),
            .in_tag    (tag_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_ready (ready_chain[i+1]),
            .out_x     (x_chain[i+1]),
            .out_y     (y_chain[i+1]),
            .out_z     (z_chain[i+1]),
            .out_tag   (tag_chain[i+1])
        );
    end

    // The accumulator holds the 90 or 270 degree offset and half an output unit,
    // so only the wrap, the truncation and the cardinal override remain here.
    always_comb begin
        z_end   = z_chain[CORDIC_STAGES];
        tag_end = tag_chain[CORDIC_STAGES];
        if (z_end < BIAS) begin
            z_wrap = z_end + FULL;
        end else if (z_end >= WRAP_HI) begin
            z_wrap = z_end - FULL;
        end else begin
            z_wrap = z_end;
        end
        angle = (z_wrap >= FULL) ? '0 : z_wrap[RSHIFT +: BW];
        unique case (tag_end.card)
            CARD_UP:    card_val = '0;
            CARD_RIGHT: card_val = B_90;
            CARD_DOWN:  card_val = B_180;
            CARD_LEFT:  card_val = B_270;
            default:    card_val = '0;
        endcase
        m_bearing_next = tag_end.special ? card_val : angle;
    end

    assign ready_chain[CORDIC_STAGES] = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ready_chain[CORDIC_STAGES]) begin
            m_valid_reg <= valid_chain[CORDIC_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_chain[CORDIC_STAGES] && valid_chain[CORDIC_STAGES]) begin
            m_bearing_reg <= m_bearing_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_bearing = m_bearing_reg;

endmodule

`default_nettype wire

FILE: sv/pbd_checker.sv
// ---------------------------------------------------------------------------
// Point bearing checker
// Port-level properties of the bearing block, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "point_bearing_degrees_macros.svh"

module pbd_checker #(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic signed [COORD_WIDTH-1:0] s_from_x,
    input logic signed [COORD_WIDTH-1:0] s_from_y,
    input logic signed [COORD_WIDTH-1:0] s_to_x,
    input logic signed [COORD_WIDTH-1:0] s_to_y,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [8+ANGLE_FRAC_BITS:0]    m_bearing
);
    localparam int BW = 9 + ANGLE_FRAC_BITS;
    localparam logic [BW-1:0] FULL_TURN = BW'(360 * (2 ** ANGLE_FRAC_BITS));

    // The input side stalls only when every stage is full behind a stalled output.
    `PBD_ASSERT_SAME(a_stall_only_when_full, !s_ready, m_valid && !m_ready, "input stall")

    // A bearing never reaches a full turn.
    `PBD_ASSERT_SAME(a_bearing_range, m_valid, m_bearing < FULL_TURN, "bearing out of range")

    // A pending result transaction holds its value.
    `PBD_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_bearing), "result")

    // A pending input transaction holds its points.
    `PBD_ASSERT_NEXT(a_input_hold, s_valid && !s_ready, s_valid && $stable({s_from_x, s_from_y, s_to_x, s_to_y}), "input")

endmodule

bind point_bearing_degrees pbd_checker #(
    .COORD_WIDTH     (COORD_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_pbd_checker (.*);

`default_nettype wire

FILE: verif/point_bearing_degrees_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Point bearing testbench
// Drives pairs of points into the bearing block and checks each returned
// bearing against a shift-add CORDIC predictor run on the same pair. A short
// directed set covers the axes, coincident points, the coordinate extremes
// and the wrap of a rounded full turn; random pairs follow under three
// pacing phases on the input and result channels.
// ---------------------------------------------------------------------------

module point_bearing_degrees_tb;

    localparam int COORD_WIDTH     = 16;
    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int BEAR_W          = 9 + ANGLE_FRAC_BITS;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int DRAIN_CYCLES     = 40;
    localparam int MAX_REPORTS      = 20;

    localparam int     ACC_FRAC   = 20;
    localparam int     GUARD_BITS = 16;
    localparam longint DEG_ONE    = 64'sd1 << ACC_FRAC;
    localparam longint TURN       = 360 * DEG_ONE;
    localparam int     ROUND_SH   = ACC_FRAC - ANGLE_FRAC_BITS;

    localparam logic [BEAR_W-1:0] BEAR_UP    = '0;
    localparam logic [BEAR_W-1:0] BEAR_RIGHT = BEAR_W'(90 << ANGLE_FRAC_BITS);
    localparam logic [BEAR_W-1:0] BEAR_DOWN  = BEAR_W'(180 << ANGLE_FRAC_BITS);
    localparam logic [BEAR_W-1:0] BEAR_LEFT  = BEAR_W'(270 << ANGLE_FRAC_BITS);

    // Arctangent of 2^-i degrees, scaled by 2^20 and rounded to nearest.
    localparam longint ATAN_DEG [0:CORDIC_STAGES-1] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833
    };

    localparam logic signed [COORD_WIDTH-1:0] EDGES [0:4] = '{
        16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] fx;
        logic signed [COORD_WIDTH-1:0] fy;
        logic signed [COORD_WIDTH-1:0] tx;
        logic signed [COORD_WIDTH-1:0] ty;
    } pair_t;

    typedef struct packed {
        pair_t             pair;
        logic [BEAR_W-1:0] bearing;
    } bearing_exp_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [COORD_WIDTH-1:0] s_from_x = '0;
    logic signed [COORD_WIDTH-1:0] s_from_y = '0;
    logic signed [COORD_WIDTH-1:0] s_to_x   = '0;
    logic signed [COORD_WIDTH-1:0] s_to_y   = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [BEAR_W-1:0] m_bearing;

    logic in_fire = 1'b0;
    int   send_idle_pct = 10;
    int   recv_idle_pct = 69;
    int   mismatches = 0;
    int   accepted = 0;
    int   checked = 0;
    int   axis_pairs = 0;
    int   wrapped_to_up = 0;

    pair_t        pending_pairs[$];
    bearing_exp_t expected_bearings[$];

    point_bearing_degrees #(
        .COORD_WIDTH    (COORD_WIDTH),
        .CORDIC_STAGES  (CORDIC_STAGES),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_from_x (s_from_x),
        .s_from_y (s_from_y),
        .s_to_x   (s_to_x),
        .s_to_y   (s_to_y),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_bearing(m_bearing)
    );

    function automatic logic [BEAR_W-1:0] bearing_of(pair_t p);
        longint dx, dy, x, y, z, xs, ys, r;
        dx = longint'($signed(p.tx)) - longint'($signed(p.fx));
        dy = longint'($signed(p.ty)) - longint'($signed(p.fy));
        if (dx == 0) begin
            return (dy < 0) ? BEAR_UP : BEAR_DOWN;
        end
        if (dy == 0) begin
            return (dx < 0) ? BEAR_LEFT : BEAR_RIGHT;
        end
        x = dx;
        y = dy;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 180 * DEG_ONE;
        end
        x = x <<< GUARD_BITS;
        y = y <<< GUARD_BITS;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_DEG[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_DEG[i];
            end
        end
        z = z + 90 * DEG_ONE;
        while (z < 0) z = z + TURN;
        while (z >= TURN) z = z - TURN;
        r = (z + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
        if (r >= (longint'(360) << ANGLE_FRAC_BITS)) begin
            r = 0;
        end
        return r[BEAR_W-1:0];
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int    d;
        p.fx = COORD_WIDTH'($urandom);
        p.fy = COORD_WIDTH'($urandom);
        p.tx = COORD_WIDTH'($urandom);
        p.ty = COORD_WIDTH'($urandom);
        case ($urandom_range(9))
            0, 1: begin
                d = $urandom_range(16);
                p.tx = p.fx + COORD_WIDTH'(d - 8);
                d = $urandom_range(16);
                p.ty = p.fy + COORD_WIDTH'(d - 8);
            end
            2: begin
                if ($urandom_range(1)) p.tx = p.fx;
                else p.ty = p.fy;
            end
            3: begin
                d = $urandom_range(6);
                if ($urandom_range(1)) p.tx = p.fx + COORD_WIDTH'(d - 3);
                else p.ty = p.fy + COORD_WIDTH'(d - 3);
            end
            4: begin
                p.fx = EDGES[$urandom_range(4)];
                p.fy = EDGES[$urandom_range(4)];
                p.tx = EDGES[$urandom_range(4)];
                p.ty = EDGES[$urandom_range(4)];
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic push_pair(input int fx, input int fy, input int tx, input int ty);
        pair_t p;
        p.fx = fx[COORD_WIDTH-1:0];
        p.fy = fy[COORD_WIDTH-1:0];
        p.tx = tx[COORD_WIDTH-1:0];
        p.ty = ty[COORD_WIDTH-1:0];
        pending_pairs.push_back(p);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        pair_t p;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || in_fire) begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    p = pending_pairs.pop_front();
                    s_from_x <= p.fx;
                    s_from_y <= p.fy;
                    s_to_x   <= p.tx;
                    s_to_y   <= p.ty;
                    s_valid  <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        bearing_exp_t e;
        in_fire <= s_valid && (s_ready === 1'b1);
        if (aresetn) begin
            if (m_valid === 1'b1 && m_ready) begin
                if (expected_bearings.size() == 0) begin
                    report_mismatch($sformatf("result transaction %0d with nothing expected",
                                              m_bearing));
                end else begin
                    e = expected_bearings.pop_front();
                    checked++;
                    if (m_bearing !== e.bearing) begin
                        report_mismatch($sformatf(
                            "(%0d,%0d)->(%0d,%0d) bearing %0d, expected %0d",
                            e.pair.fx, e.pair.fy, e.pair.tx, e.pair.ty,
                            m_bearing, e.bearing));
                    end
                end
            end
            if (s_valid && s_ready === 1'b1) begin
                e.pair.fx = s_from_x;
                e.pair.fy = s_from_y;
                e.pair.tx = s_to_x;
                e.pair.ty = s_to_y;
                e.bearing = bearing_of(e.pair);
                expected_bearings.push_back(e);
                accepted++;
                if (s_from_x == s_to_x || s_from_y == s_to_y) axis_pairs++;
                if (e.bearing == BEAR_UP && s_from_x != s_to_x) wrapped_to_up++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        push_pair(0, 0, 0, 0);
        push_pair(-32768, 32767, -32768, 32767);
        push_pair(0, 10, 0, -10);
        push_pair(0, -32768, 0, 32767);
        push_pair(0, 32767, 0, -32768);
        push_pair(-32768, 0, 32767, 0);
        push_pair(32767, 0, -32768, 0);
        push_pair(0, 0, 1, 1);
        push_pair(0, 0, -1, 1);
        push_pair(0, 0, -1, -1);
        push_pair(0, 0, 1, -1);
        push_pair(-32768, -32768, 32767, 32767);
        push_pair(32767, 32767, -32768, -32768);
        push_pair(-32768, 32767, 32767, -32768);
        push_pair(32767, -32768, -32768, 32767);
        push_pair(0, 0, -1, -32767);
        push_pair(1, 32767, 0, -32768);
        push_pair(0, 0, 1, -32767);
        push_pair(0, 0, 1, 32767);
        push_pair(0, 0, -1, 32767);
        push_pair(0, 0, 32767, 1);
        push_pair(0, 0, 32767, -1);
        push_pair(0, 0, -32768, 1);
        push_pair(0, 0, -32768, -1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 10;
                    recv_idle_pct = 69;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_idle_pct = 10;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pending_pairs.push_back(random_pair());
            end
            while (pending_pairs.size() != 0 || s_valid) @(posedge aclk);
        end

        while (expected_bearings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d of %0d bearings over three pacing phases.", checked, accepted);
        $display("%0d pairs lay on an axis or coincided; %0d rounded a full turn to up.",
                 axis_pairs, wrapped_to_up);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
